// File: rtl/core/didoc_pkg.sv
`timescale 1ns / 1ps

package didoc_pkg;

  // screen power modes
  typedef enum logic [1:0] {
    MODE_ON  = 2'd0,
    MODE_DIM = 2'd1,
    MODE_OFF = 2'd2
  } mode_t;

  // item kinds
  localparam logic [1:0] KIND_TICK     = 2'd0;
  localparam logic [1:0] KIND_ACTIVITY = 2'd1;
  localparam logic [1:0] KIND_INHIBIT  = 2'd2;
  localparam logic [1:0] KIND_KEY      = 2'd3;

  // key events
  localparam logic [1:0] KEY_OTHER = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_DIM_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_OFF_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_FULL_LEVEL  = 2'd2;
  localparam logic [1:0] REG_DIM_LEVEL   = 2'd3;

  // reset values of the configuration registers
  localparam logic [31:0] DIM_TIMEOUT_RST = 32'd35000;
  localparam logic [31:0] OFF_TIMEOUT_RST = 32'd45000;
  localparam logic [6:0]  FULL_LEVEL_RST  = 7'd100;
  localparam logic [6:0]  DIM_LEVEL_RST   = 7'd20;
  localparam logic [6:0]  PCT_MAX         = 7'd100;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_time_ms;
    logic        inhibit_value;
    logic [1:0]  key_event;
  } in_item_t;

  typedef struct packed {
    logic [1:0] screen_state;
    logic [6:0] backlight_pct;
    logic       backlight_write;
    logic       key_consumed;
    logic       wake_beep;
    logic       inhibited_now;
  } out_item_t;

  typedef struct packed {
    logic [31:0] dim_timeout_ms;
    logic [31:0] off_timeout_ms;
    logic [6:0]  full_level_pct;
    logic [6:0]  dim_level_pct;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] last_time;
    logic        inhibit;
  } state_t;

  // clamp a level to one hundred percent
  function automatic logic [6:0] sat_pct(input logic [6:0] v);
    sat_pct = (v > PCT_MAX) ? PCT_MAX : v;
  endfunction

endpackage

// File: rtl/core/didoc_cfg.sv
`timescale 1ns / 1ps

module didoc_cfg import didoc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [31:0] wr_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  // register file, one write per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dim_timeout_ms <= DIM_TIMEOUT_RST;
      cfg_r.off_timeout_ms <= OFF_TIMEOUT_RST;
      cfg_r.full_level_pct <= FULL_LEVEL_RST;
      cfg_r.dim_level_pct  <= DIM_LEVEL_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_DIM_TIMEOUT: cfg_r.dim_timeout_ms <= wr_data;
        REG_OFF_TIMEOUT: cfg_r.off_timeout_ms <= wr_data;
        REG_FULL_LEVEL:  cfg_r.full_level_pct <= wr_data[6:0];
        REG_DIM_LEVEL:   cfg_r.dim_level_pct  <= wr_data[6:0];
        default: ;
      endcase
    end
  end

  // levels are clamped on the way out
  always_comb begin
    cfg = cfg_r;
    cfg.full_level_pct = sat_pct(cfg_r.full_level_pct);
    cfg.dim_level_pct  = sat_pct(cfg_r.dim_level_pct);
  end

endmodule

// File: rtl/core/didoc_step.sv
`timescale 1ns / 1ps

module didoc_step import didoc_pkg::*; (
  input  cfg_t      cfg,
  input  state_t    state,
  input  in_item_t  item,
  output state_t    state_nxt,
  output out_item_t result
);

  logic [31:0] elapsed;
  logic        hit_off;
  logic        hit_dim;
  logic        wake;
  logic        wr;
  logic        consumed;

  // idle time, zero when the clock appears to run backwards
  assign elapsed = (item.now_time_ms >= state.last_time) ?
                   (item.now_time_ms - state.last_time) : 32'd0;
  assign hit_off = (elapsed >= cfg.off_timeout_ms);
  assign hit_dim = (elapsed >= cfg.dim_timeout_ms);

  // next state per item kind
  always_comb begin
    state_nxt = state;
    wake      = 1'b0;
    wr        = 1'b0;
    consumed  = 1'b0;
    case (item.kind)
      KIND_TICK: begin
        if (state.inhibit) begin
          wake = 1'b1;
        end else if (state.mode == MODE_ON) begin
          if (hit_off) begin
            state_nxt.mode = MODE_OFF;
            wr = 1'b1;
          end else if (hit_dim) begin
            state_nxt.mode = MODE_DIM;
            wr = 1'b1;
          end
        end else if (state.mode == MODE_DIM) begin
          if (hit_off) begin
            state_nxt.mode = MODE_OFF;
            wr = 1'b1;
          end
        end
      end
      KIND_ACTIVITY: begin
        wake = 1'b1;
      end
      KIND_INHIBIT: begin
        state_nxt.inhibit = item.inhibit_value;
        wake = item.inhibit_value;
      end
      KIND_KEY: begin
        if (item.key_event != KEY_OTHER) begin
          wake = 1'b1;
          consumed = (state.mode == MODE_OFF);
        end
      end
      default: ;
    endcase

    // activity restarts idle time and turns the screen on
    if (wake) begin
      state_nxt.last_time = item.now_time_ms;
      if (state.mode != MODE_ON) begin
        state_nxt.mode = MODE_ON;
        wr = 1'b1;
      end
    end
  end

  // result fields
  always_comb begin
    result.screen_state = state_nxt.mode;
    case (state_nxt.mode)
      MODE_ON:  result.backlight_pct = cfg.full_level_pct;
      MODE_DIM: result.backlight_pct = cfg.dim_level_pct;
      default:  result.backlight_pct = 7'd0;
    endcase
    result.backlight_write = wr;
    result.key_consumed    = consumed;
    result.wake_beep       = consumed;
    result.inhibited_now   = state_nxt.inhibit;
  end

endmodule

// File: rtl/core/display_idle_dim_off_controller.sv
`timescale 1ns / 1ps

// Three-state backlight controller (on, dim, off). One item is accepted every
// cycle unless the output stalls; the item is captured in an
// input register, the idle-time subtraction and the two timeout compares run
// in one pass against the mode, last-activity and inhibit registers, and the
// result lands in an output register. A stalled output holds the input
// register, so each side keeps full rate while the other is ready. The user must
// write timeouts and levels via the cfg port only while no item is in flight;
// the block does not enforce it. Levels above one hundred read as one hundred.
module display_idle_dim_off_controller import didoc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t      cfg;
  state_t    state_r;
  state_t    state_nxt;
  in_item_t  in_item_r;
  logic      in_valid_r;
  out_item_t out_r;
  out_item_t result;
  logic      out_valid_r;
  logic      adv;
  logic      fire;

  assign cfg_ready = 1'b1;

  didoc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  didoc_step u_step (
    .cfg       (cfg),
    .state     (state_r),
    .item      (in_item_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  // handshake: output register frees, item moves on
  assign adv      = !out_valid_r || out_ready;
  assign fire     = in_valid_r && adv;
  assign in_ready = !in_valid_r || adv;

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      state_r.mode    <= MODE_ON;
      state_r.last_time <= 32'd0;
      state_r.inhibit <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
      end
      if (fire) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_item;
    end
    if (fire) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // a backlight write goes with a change of mode
  a_write_changes_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && result.backlight_write) |=> (state_r.mode != $past(state_r.mode)))
    else $error("backlight write without mode change");

  // no write, no change of mode
  a_mode_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && result.backlight_write) |=> $stable(state_r.mode))
    else $error("mode changed without backlight write");

  // a consumed key always leaves the screen on
  a_consumed_on: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.key_consumed) |->
      (out_r.screen_state == MODE_ON && out_r.wake_beep))
    else $error("consumed key without wake");

  // inhibit keeps the screen on
  a_inhibit_on: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.inhibited_now) |-> (out_r.screen_state == MODE_ON))
    else $error("screen not on under inhibit");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import didoc_pkg::*;

  // key events that count as a press
  localparam logic [1:0] KEY_CLICK = 2'd0;
  localparam logic [1:0] KEY_PRESS = 2'd1;
  localparam logic [1:0] KEY_LONG  = 2'd2;

  localparam int RANDOM_ITEMS = 800;
  localparam int SEGMENTS     = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // own copy of the timeouts and levels
  logic [31:0] dim_after_ms = DIM_TIMEOUT_RST;
  logic [31:0] off_after_ms = OFF_TIMEOUT_RST;
  logic [6:0]  full_pct = FULL_LEVEL_RST;
  logic [6:0]  dim_pct = DIM_LEVEL_RST;

  // own copy of the screen state
  mode_t       model_mode = MODE_ON;
  logic [31:0] model_last_ms = '0;
  logic        model_inhibit = 1'b0;

  out_item_t   screen_results_due[$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          err_count = 0;
  logic [31:0] clock_ms = '0;

  always #10 clk = ~clk;

  display_idle_dim_off_controller u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // activity: restart idle time, bring the screen back on
  function automatic logic wake_screen(input logic [31:0] now);
    model_last_ms = now;
    if (model_mode != MODE_ON) begin
      model_mode = MODE_ON;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // advance the screen state by one item and work out its result
  function automatic out_item_t compute_screen_result(input in_item_t it);
    out_item_t   res;
    logic [31:0] idle_ms;
    logic [6:0]  lvl;
    res = '0;
    case (it.kind)
      KIND_TICK: begin
        if (model_inhibit) begin
          res.backlight_write = wake_screen(it.now_time_ms);
        end else begin
          // a clock that runs backwards counts as no idle time
          idle_ms = (it.now_time_ms >= model_last_ms) ?
                    it.now_time_ms - model_last_ms : 32'd0;
          if (model_mode == MODE_ON) begin
            if (idle_ms >= off_after_ms) begin
              model_mode = MODE_OFF;
              res.backlight_write = 1'b1;
            end else if (idle_ms >= dim_after_ms) begin
              model_mode = MODE_DIM;
              res.backlight_write = 1'b1;
            end
          end else if (model_mode == MODE_DIM && idle_ms >= off_after_ms) begin
            model_mode = MODE_OFF;
            res.backlight_write = 1'b1;
          end
        end
      end
      KIND_ACTIVITY: begin
        res.backlight_write = wake_screen(it.now_time_ms);
      end
      KIND_INHIBIT: begin
        model_inhibit = it.inhibit_value;
        if (it.inhibit_value) res.backlight_write = wake_screen(it.now_time_ms);
      end
      default: begin
        if (it.key_event != KEY_OTHER) begin
          if (model_mode == MODE_OFF) begin
            res.key_consumed = 1'b1;
            res.wake_beep = 1'b1;
            res.backlight_write = wake_screen(it.now_time_ms);
          end else if (model_mode == MODE_DIM) begin
            res.backlight_write = wake_screen(it.now_time_ms);
          end else begin
            model_last_ms = it.now_time_ms;
          end
        end
      end
    endcase
    lvl = (model_mode == MODE_ON) ? full_pct : (model_mode == MODE_DIM) ? dim_pct : 7'd0;
    res.screen_state = model_mode;
    res.backlight_pct = (lvl > PCT_MAX) ? PCT_MAX : lvl;
    res.inhibited_now = model_inhibit;
    return res;
  endfunction

  // send one item, idling first at the current rate
  task automatic send_event(input logic [1:0] kind, input logic [31:0] now,
                            input logic inh, input logic [1:0] key);
    in_item_t it;
    it.kind = kind;
    it.now_time_ms = now;
    it.inhibit_value = inh;
    it.key_event = key;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    screen_results_due.push_back(compute_screen_result(it));
  endtask

  // hold off the sender until every result is back
  task automatic drain_screen_results();
    in_valid <= 1'b0;
    while (screen_results_due.size() != 0) @(posedge clk);
  endtask

  // write all four registers while the block is idle
  task automatic load_config(input logic [31:0] dim_ms, input logic [31:0] off_ms,
                             input logic [6:0] full_lvl, input logic [6:0] dim_lvl);
    logic [31:0] vals[4];
    drain_screen_results();
    vals = '{dim_ms, off_ms, {25'd0, full_lvl}, {25'd0, dim_lvl}};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (i[1:0])
        REG_DIM_TIMEOUT: dim_after_ms = vals[i];
        REG_OFF_TIMEOUT: off_after_ms = vals[i];
        REG_FULL_LEVEL:  full_pct = vals[i][6:0];
        REG_DIM_LEVEL:   dim_pct = vals[i][6:0];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_count++;
    end
  endtask

  // receiver stalls and result checking
  always @(posedge clk) begin : check_results
    out_item_t due;
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      if (screen_results_due.size() == 0) begin
        $error("result with nothing expected: %p", out_item);
        err_count++;
      end else begin
        due = screen_results_due.pop_front();
        check_field("screen_state", due.screen_state, out_item.screen_state);
        check_field("backlight_pct", due.backlight_pct, out_item.backlight_pct);
        check_field("backlight_write", due.backlight_write, out_item.backlight_write);
        check_field("key_consumed", due.key_consumed, out_item.key_consumed);
        check_field("wake_beep", due.wake_beep, out_item.wake_beep);
        check_field("inhibited_now", due.inhibited_now, out_item.inhibited_now);
      end
    end
  end

  // default timeouts: dim and off boundaries, backwards clock, wake key
  task automatic test_timeouts();
    send_event(KIND_TICK, 32'd34999, 1'b0, KEY_CLICK);
    send_event(KIND_TICK, 32'd35000, 1'b1, KEY_PRESS);
    send_event(KIND_TICK, 32'd44999, 1'b0, KEY_LONG);
    send_event(KIND_TICK, 32'd45000, 1'b0, KEY_OTHER);
    send_event(KIND_KEY, 32'd50000, 1'b1, KEY_OTHER);
    send_event(KIND_KEY, 32'd50000, 1'b0, KEY_CLICK);
    send_event(KIND_TICK, 32'd40000, 1'b1, KEY_CLICK);
    send_event(KIND_TICK, 32'hFFFF_FFFF, 1'b0, KEY_CLICK);
  endtask

  // key events in each state, plain activity
  task automatic test_key_wake();
    send_event(KIND_KEY, 32'd100, 1'b0, KEY_PRESS);
    send_event(KIND_TICK, 32'd35100, 1'b0, KEY_CLICK);
    send_event(KIND_KEY, 32'd35200, 1'b1, KEY_LONG);
    send_event(KIND_KEY, 32'd70000, 1'b0, KEY_CLICK);
    send_event(KIND_TICK, 32'd105000, 1'b0, KEY_CLICK);
    send_event(KIND_ACTIVITY, 32'd105001, 1'b1, KEY_OTHER);
  endtask

  // inhibit holds the screen on; setting it wakes an off screen
  task automatic test_inhibit();
    send_event(KIND_INHIBIT, 32'd200000, 1'b1, KEY_CLICK);
    send_event(KIND_TICK, 32'hFFFF_FFFF, 1'b0, KEY_CLICK);
    send_event(KIND_INHIBIT, 32'd0, 1'b0, KEY_CLICK);
    send_event(KIND_ACTIVITY, 32'd0, 1'b0, KEY_CLICK);
    send_event(KIND_TICK, 32'd45000, 1'b0, KEY_CLICK);
    send_event(KIND_INHIBIT, 32'd45001, 1'b1, KEY_OTHER);
    send_event(KIND_INHIBIT, 32'd45002, 1'b0, KEY_OTHER);
  endtask

  // zero and full-range timeouts, levels above one hundred, dim not below off
  task automatic test_register_extremes();
    load_config(32'hFFFF_FFFF, 32'd0, 7'd127, 7'd127);
    send_event(KIND_TICK, 32'd1, 1'b0, KEY_CLICK);
    send_event(KIND_ACTIVITY, 32'd2, 1'b0, KEY_CLICK);
    load_config(32'd0, 32'hFFFF_FFFF, 7'd0, 7'd101);
    send_event(KIND_TICK, 32'd2, 1'b0, KEY_CLICK);
    send_event(KIND_TICK, 32'hFFFF_FFFF, 1'b0, KEY_CLICK);
    send_event(KIND_ACTIVITY, 32'd5, 1'b0, KEY_CLICK);
    load_config(32'd500, 32'd300, 7'd100, 7'd0);
    send_event(KIND_TICK, 32'd405, 1'b0, KEY_CLICK);
  endtask

  // idle/dim/off cycles with random timing under changing settings and rates
  task automatic test_random_traffic();
    logic [1:0]  kind;
    logic [1:0]  key;
    logic        inh;
    logic [31:0] longest;
    int          roll;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 3) begin
        send_idle_pct = 37;
        recv_idle_pct = 88;
      end else if (seg < 6) begin
        send_idle_pct = 88;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // each segment drains the block before its settings change
      case (seg)
        5: load_config($urandom, $urandom, 7'($urandom_range(0, 127)),
                       7'($urandom_range(0, 127)));
        7: load_config(DIM_TIMEOUT_RST, OFF_TIMEOUT_RST, FULL_LEVEL_RST, DIM_LEVEL_RST);
        default: load_config($urandom_range(1, 3000), $urandom_range(1, 4000),
                             7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
      endcase
      longest = (off_after_ms > dim_after_ms) ? off_after_ms : dim_after_ms;
      clock_ms = $urandom;
      for (int n = 0; n < RANDOM_ITEMS / SEGMENTS; n++) begin
        // time: mostly forward steps, some timeout boundaries, jumps and noise
        roll = $urandom_range(99);
        if (roll < 70) clock_ms = clock_ms + $urandom_range(0, longest / 2 + 1);
        else if (roll < 80) clock_ms = model_last_ms + dim_after_ms - $urandom_range(0, 1);
        else if (roll < 90) clock_ms = model_last_ms + off_after_ms - $urandom_range(0, 1);
        else if (roll < 95) clock_ms = clock_ms - $urandom_range(0, longest / 2 + 1);
        else clock_ms = $urandom;
        roll = $urandom_range(99);
        if (roll < 60) kind = KIND_TICK;
        else if (roll < 70) kind = KIND_ACTIVITY;
        else if (roll < 78) kind = KIND_INHIBIT;
        else kind = KIND_KEY;
        if (kind == KIND_INHIBIT) inh = ($urandom_range(99) < 30);
        else inh = 1'($urandom_range(0, 1));
        key = ($urandom_range(99) < 25) ? KEY_OTHER : 2'($urandom_range(0, 2));
        send_event(kind, clock_ms, inh, key);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_timeouts();
    test_key_wake();
    test_inhibit();
    test_register_extremes();
    test_random_traffic();
    drain_screen_results();
    repeat (8) @(posedge clk);
    if (err_count == 0 && screen_results_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: files.f
rtl/core/didoc_pkg.sv
rtl/core/didoc_cfg.sv
rtl/core/didoc_step.sv
rtl/core/display_idle_dim_off_controller.sv
tb/sv/testbench.sv
